[rtl/double_ended_queue_top_macros.svh]
// ----------------------------------------------------------------------------
// double_ended_queue_top_macros.svh
// assertion macros for the deque top level
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DQ_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define DQ_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/dq_pkg.sv]
// ----------------------------------------------------------------------------
// dq_pkg
// sizes, command and status codes for the double-ended queue
// ----------------------------------------------------------------------------
`default_nettype none

package dq_pkg;

   localparam int DEPTH        = 16;
   localparam int DATA_WIDTH   = 32;
   localparam int IDX_WIDTH    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_WIDTH    = $clog2(DEPTH + 1);
   localparam int SUM_WIDTH    = IDX_WIDTH + 1;

   // fixed port field widths
   localparam int CMD_WIDTH    = 3;
   localparam int WORD_WIDTH   = 32;
   localparam int STATUS_WIDTH = 2;
   localparam int TOTAL_WIDTH  = 5;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_PUSH_FRONT = 3'd0,
      CMD_PUSH_BACK  = 3'd1,
      CMD_POP_FRONT  = 3'd2,
      CMD_POP_BACK   = 3'd3,
      CMD_PEEK_FRONT = 3'd4,
      CMD_PEEK_BACK  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // result of a command while its read is in flight
   typedef struct packed {
      logic                 rd_valid;
      status_type           status;
      logic                 is_empty;
      logic [CNT_WIDTH-1:0] total;
   } meta_type;

endpackage

`default_nettype wire

[rtl/double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_top
// bounded deque of data words in a circular memory with front index and count
// ----------------------------------------------------------------------------
//
//   channel  ports                                   direction  role
//   req      req_valid/req_ready, cmd, push_value    in         one command
//   rsp      rsp_valid/rsp_ready, read_value, status out        one result
//            is_empty, entry_total
//
// one command transfer per cycle while rsp_ready is high; the result passes
// the memory read register, then the output register
// index and count update at the command transfer, so a pop right after a push
// reads the already written entry without forwarding
// reset clears front index, count and valid flags; the store is
// not cleared and only held entries are ever read
// with rsp_ready low the output register holds, one more command parks in the
// read stage, then req_ready drops
`default_nettype none

`include "double_ended_queue_top_macros.svh"

module double_ended_queue_top (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_ready,
   input  wire logic [dq_pkg::CMD_WIDTH-1:0]     req_cmd,
   input  wire logic [dq_pkg::WORD_WIDTH-1:0]    req_push_value,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_ready,
   output logic [dq_pkg::WORD_WIDTH-1:0]         rsp_read_value,
   output logic [dq_pkg::STATUS_WIDTH-1:0]       rsp_status,
   output logic                                  rsp_is_empty,
   output logic [dq_pkg::TOTAL_WIDTH-1:0]        rsp_entry_total
);

   localparam logic [dq_pkg::IDX_WIDTH-1:0] LAST_IDX =
      dq_pkg::IDX_WIDTH'(dq_pkg::DEPTH - 1);
   localparam logic [dq_pkg::CNT_WIDTH-1:0] FULL_CNT =
      dq_pkg::CNT_WIDTH'(dq_pkg::DEPTH);
   localparam logic [dq_pkg::SUM_WIDTH-1:0] SUM_DEPTH =
      dq_pkg::SUM_WIDTH'(dq_pkg::DEPTH);

   // deque storage, one write and one read port
   logic [dq_pkg::DATA_WIDTH-1:0] entry_store [dq_pkg::DEPTH];

   // control state
   logic [dq_pkg::IDX_WIDTH-1:0] front_ff, front_in;
   logic [dq_pkg::CNT_WIDTH-1:0] count_ff, count_in;

   // read stage
   logic                          s1_valid_ff;
   dq_pkg::meta_type              s1_meta_ff, s1_meta_in;
   logic [dq_pkg::DATA_WIDTH-1:0] rd_data_ff;

   // output register
   logic                            rsp_valid_ff;
   logic [dq_pkg::WORD_WIDTH-1:0]   rsp_read_value_ff;
   dq_pkg::status_type              rsp_status_ff;
   logic                            rsp_is_empty_ff;
   logic [dq_pkg::TOTAL_WIDTH-1:0]  rsp_entry_total_ff;

   dq_pkg::cmd_type              cmd_s;
   logic                         req_fire;
   logic                         out_load;
   logic                         is_full, is_none;
   logic                         wr_en, rd_en;
   logic [dq_pkg::IDX_WIDTH-1:0] wr_addr, rd_addr;
   logic [dq_pkg::IDX_WIDTH-1:0] front_next, front_prev;
   logic [dq_pkg::IDX_WIDTH-1:0] tail_slot, back_slot;
   logic [dq_pkg::SUM_WIDTH-1:0] tail_sum;

   // handshake: read stage drains into the output register when it is free
   assign out_load  = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || out_load;
   assign req_fire  = req_valid && req_ready;

   assign cmd_s   = dq_pkg::cmd_type'(req_cmd);
   assign is_full = (count_ff == FULL_CNT);
   assign is_none = (count_ff == '0);

   // circular index arithmetic
   assign front_next = (front_ff == LAST_IDX) ? '0 : front_ff + 1'b1;
   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - 1'b1;
   assign tail_sum   = dq_pkg::SUM_WIDTH'(front_ff) + dq_pkg::SUM_WIDTH'(count_ff);
   assign tail_slot  = (tail_sum >= SUM_DEPTH) ?
                       dq_pkg::IDX_WIDTH'(tail_sum - SUM_DEPTH) :
                       dq_pkg::IDX_WIDTH'(tail_sum);
   assign back_slot  = (tail_slot == '0) ? LAST_IDX : tail_slot - 1'b1;

   // command decode
   always_comb begin
      front_in          = front_ff;
      count_in          = count_ff;
      wr_en             = 1'b0;
      rd_en             = 1'b0;
      wr_addr           = tail_slot;
      rd_addr           = front_ff;
      s1_meta_in.status = dq_pkg::ST_OK;
      case (cmd_s)
         dq_pkg::CMD_PUSH_FRONT: begin
            if (is_full) begin
               s1_meta_in.status = dq_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = front_prev;
               front_in = front_prev;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::CMD_PUSH_BACK: begin
            if (is_full) begin
               s1_meta_in.status = dq_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + 1'b1;
            end
         end
         dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_PEEK_FRONT: begin
            if (is_none) begin
               s1_meta_in.status = dq_pkg::ST_EMPTY;
            end else begin
               rd_en = 1'b1;
               if (cmd_s == dq_pkg::CMD_POP_FRONT) begin
                  front_in = front_next;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         dq_pkg::CMD_POP_BACK, dq_pkg::CMD_PEEK_BACK: begin
            if (is_none) begin
               s1_meta_in.status = dq_pkg::ST_EMPTY;
            end else begin
               rd_en   = 1'b1;
               rd_addr = back_slot;
               if (cmd_s == dq_pkg::CMD_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
            // unused codes: no operation
         end
      endcase
      s1_meta_in.rd_valid = rd_en;
      s1_meta_in.is_empty = (count_in == '0);
      s1_meta_in.total    = count_in;
   end

   // memory: write and registered read, both only on a command transfer
   always_ff @(posedge clock) begin
      if (req_fire && wr_en) begin
         entry_store[wr_addr] <= dq_pkg::DATA_WIDTH'(req_push_value);
      end
      if (req_fire && rd_en) begin
         rd_data_ff <= entry_store[rd_addr];
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff     <= '0;
         count_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            front_ff <= front_in;
            count_ff <= count_in;
         end
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_meta_ff <= s1_meta_in;
      end
      if (out_load) begin
         rsp_read_value_ff  <= s1_meta_ff.rd_valid ?
                               dq_pkg::WORD_WIDTH'(rd_data_ff) : '0;
         rsp_status_ff      <= s1_meta_ff.status;
         rsp_is_empty_ff    <= s1_meta_ff.is_empty;
         rsp_entry_total_ff <= dq_pkg::TOTAL_WIDTH'(s1_meta_ff.total);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_read_value  = rsp_read_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_is_empty    = rsp_is_empty_ff;
   assign rsp_entry_total = rsp_entry_total_ff;

   // checks on the deque bookkeeping
   `DQ_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= FULL_CNT, "count above depth")
   `DQ_ASSERT_NOW(a_full_total, clock, reset, rsp_valid_ff && rsp_status_ff == dq_pkg::ST_FULL, rsp_entry_total_ff == dq_pkg::TOTAL_WIDTH'(dq_pkg::DEPTH), "full status without full count")
   `DQ_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid_ff && rsp_status_ff == dq_pkg::ST_EMPTY, rsp_is_empty_ff && rsp_read_value_ff == '0, "empty status with data or entries")
   `DQ_ASSERT_NEXT(a_push_count, clock, reset, req_fire && wr_en, count_ff == $past(count_ff) + 1'b1, "push did not grow count")

endmodule

`default_nettype wire

[verif/double_ended_queue_checker.sv]
// ----------------------------------------------------------------------------
// double_ended_queue_checker
// tracks the deque contents from command transfers and checks every result
// transfer against the oldest predicted result
// ----------------------------------------------------------------------------
module double_ended_queue_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_ready,
   input  wire logic [dq_pkg::CMD_WIDTH-1:0]    req_cmd,
   input  wire logic [dq_pkg::WORD_WIDTH-1:0]   req_push_value,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [dq_pkg::WORD_WIDTH-1:0]   rsp_read_value,
   input  wire logic [dq_pkg::STATUS_WIDTH-1:0] rsp_status,
   input  wire logic                            rsp_is_empty,
   input  wire logic [dq_pkg::TOTAL_WIDTH-1:0]  rsp_entry_total,
   output int                                   mismatch_count,
   output int                                   pending_count
);

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [dq_pkg::WORD_WIDTH-1:0]   read_value;
      logic [dq_pkg::STATUS_WIDTH-1:0] status;
      logic                            is_empty;
      logic [dq_pkg::TOTAL_WIDTH-1:0]  entry_total;
   } deque_result_type;

   logic [dq_pkg::DATA_WIDTH-1:0] deque_store [dq_pkg::DEPTH];
   logic [dq_pkg::IDX_WIDTH-1:0]  front_slot;
   logic [dq_pkg::CNT_WIDTH-1:0]  held_count;
   deque_result_type              expected_results [$];
   int                            errors = 0;

   // updates the tracked deque and returns the result the command should give
   function automatic deque_result_type apply_command(
      input logic [dq_pkg::CMD_WIDTH-1:0]  cmd,
      input logic [dq_pkg::WORD_WIDTH-1:0] word);
      deque_result_type             res;
      logic [dq_pkg::IDX_WIDTH-1:0] slot;
      res = '0;
      res.status = dq_pkg::ST_OK;
      case (cmd)
         dq_pkg::CMD_PUSH_FRONT, dq_pkg::CMD_PUSH_BACK: begin
            if (held_count == dq_pkg::CNT_WIDTH'(dq_pkg::DEPTH)) begin
               res.status = dq_pkg::ST_FULL;
            end else begin
               if (cmd == dq_pkg::CMD_PUSH_FRONT) begin
                  front_slot = front_slot - 1'b1;
                  slot = front_slot;
               end else begin
                  slot = front_slot + held_count[dq_pkg::IDX_WIDTH-1:0];
               end
               deque_store[slot] = dq_pkg::DATA_WIDTH'(word);
               held_count = held_count + 1'b1;
            end
         end
         dq_pkg::CMD_POP_FRONT, dq_pkg::CMD_PEEK_FRONT: begin
            if (held_count == '0) begin
               res.status = dq_pkg::ST_EMPTY;
            end else begin
               res.read_value = dq_pkg::WORD_WIDTH'(deque_store[front_slot]);
               if (cmd == dq_pkg::CMD_POP_FRONT) begin
                  front_slot = front_slot + 1'b1;
                  held_count = held_count - 1'b1;
               end
            end
         end
         dq_pkg::CMD_POP_BACK, dq_pkg::CMD_PEEK_BACK: begin
            if (held_count == '0) begin
               res.status = dq_pkg::ST_EMPTY;
            end else begin
               slot = front_slot + held_count[dq_pkg::IDX_WIDTH-1:0] - 1'b1;
               res.read_value = dq_pkg::WORD_WIDTH'(deque_store[slot]);
               if (cmd == dq_pkg::CMD_POP_BACK) begin
                  held_count = held_count - 1'b1;
               end
            end
         end
         default: ; // spare codes leave everything as it is
      endcase
      res.is_empty = (held_count == '0);
      res.entry_total = dq_pkg::TOTAL_WIDTH'(held_count);
      return res;
   endfunction

   always @(posedge clock) begin
      deque_result_type actual;
      deque_result_type expected;
      if (reset) begin
         front_slot = '0;
         held_count = '0;
         expected_results.delete();
      end else begin
         if (req_valid && req_ready) begin
            expected_results.push_back(apply_command(req_cmd, req_push_value));
         end
         if (rsp_valid && rsp_ready) begin
            actual = {rsp_read_value, rsp_status, rsp_is_empty, rsp_entry_total};
            if (expected_results.size() == 0) begin
               errors++;
               $display("%0t: unexpected result transfer, expected none, actual %h",
                        $time, actual);
            end else begin
               expected = expected_results.pop_front();
               if (actual.read_value !== expected.read_value) begin
                  errors++;
                  $display("%0t: read_value mismatch, expected %h, actual %h",
                           $time, expected.read_value, actual.read_value);
               end
               if (actual.status !== expected.status) begin
                  errors++;
                  $display("%0t: status mismatch, expected %0d, actual %0d",
                           $time, expected.status, actual.status);
               end
               if (actual.is_empty !== expected.is_empty) begin
                  errors++;
                  $display("%0t: is_empty mismatch, expected %b, actual %b",
                           $time, expected.is_empty, actual.is_empty);
               end
               if (actual.entry_total !== expected.entry_total) begin
                  errors++;
                  $display("%0t: entry_total mismatch, expected %0d, actual %0d",
                           $time, expected.entry_total, actual.entry_total);
               end
            end
         end
      end
      mismatch_count <= errors;
      pending_count  <= expected_results.size();
   end

endmodule

[verif/tb_double_ended_queue_top.sv]
// ----------------------------------------------------------------------------
// tb_double_ended_queue_top
// drives commands into the deque and takes its results with random gaps and
// stalls; a checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb_double_ended_queue_top;

   timeunit 1ns;
   timeprecision 1ps;

   // command codes the block treats as no operation
   localparam logic [dq_pkg::CMD_WIDTH-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [dq_pkg::CMD_WIDTH-1:0] CMD_SPARE_HI = 3'd7;

   localparam int RANDOM_COMMANDS = 1500;
   localparam int PAUSE_AT        = 900;    // sender waits for all results here
   localparam int HOLD_AFTER      = 400;    // receiver holds off after this many results
   localparam int HOLD_CYCLES     = 150;
   localparam int DRAIN_CYCLES    = 10;     // keep a margin past the result latency
   localparam int CYCLE_LIMIT     = 200000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [dq_pkg::CMD_WIDTH-1:0]    req_cmd = '0;
   logic [dq_pkg::WORD_WIDTH-1:0]   req_push_value = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [dq_pkg::WORD_WIDTH-1:0]   rsp_read_value;
   logic [dq_pkg::STATUS_WIDTH-1:0] rsp_status;
   logic                            rsp_is_empty;
   logic [dq_pkg::TOTAL_WIDTH-1:0]  rsp_entry_total;

   int  mismatch_count;
   int  pending_count;
   int  cycle_count = 0;
   int  results_taken = 0;
   bit  sender_idle = 1'b1;
   bit  receiver_idle = 1'b1;

   always #5 clock = ~clock;

   double_ended_queue_top dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_total (rsp_entry_total)
   );

   double_ended_queue_checker deque_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_read_value  (rsp_read_value),
      .rsp_status      (rsp_status),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_total (rsp_entry_total),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   // watchdog: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // offers one command and returns at the edge where it transfers
   // valid is only dropped when a gap is drawn, so back-to-back items keep it high
   task automatic send_command(input logic [dq_pkg::CMD_WIDTH-1:0]  cmd,
                               input logic [dq_pkg::WORD_WIDTH-1:0] value);
      int gap;
      gap = sender_idle ? $urandom_range(0, 4) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_push_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // sender goes quiet until every predicted result has come back
   // it lets a clock edge pass first so the checker has counted the last transfer
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // spare codes now and then, otherwise pushes with the given share, pops and peeks for the rest
   function automatic logic [dq_pkg::CMD_WIDTH-1:0] pick_command(input int push_pct,
                                                                 input bit peek_bias);
      int r;
      r = $urandom_range(0, 99);
      if (r < 3) begin
         return $urandom_range(0, 1) ? CMD_SPARE_HI : CMD_SPARE_LO;
      end
      if (r < 3 + push_pct) begin
         return $urandom_range(0, 1) ? dq_pkg::CMD_PUSH_BACK : dq_pkg::CMD_PUSH_FRONT;
      end
      if (peek_bias && $urandom_range(0, 2) != 0) begin
         return $urandom_range(0, 1) ? dq_pkg::CMD_PEEK_BACK : dq_pkg::CMD_PEEK_FRONT;
      end
      case ($urandom_range(0, 3))
         0:       return dq_pkg::CMD_POP_FRONT;
         1:       return dq_pkg::CMD_POP_BACK;
         2:       return dq_pkg::CMD_PEEK_FRONT;
         default: return dq_pkg::CMD_PEEK_BACK;
      endcase
   endfunction

   // mostly random words, with the all-zero and all-one extremes mixed in
   function automatic logic [dq_pkg::WORD_WIDTH-1:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      int random_sent;
      int segment_len;
      int push_pct;
      bit peek_bias;
      random_sent = 0;

      // reset held from the start, then released at a clock edge
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: every read on an empty deque
      send_command(dq_pkg::CMD_POP_FRONT,  pick_word());
      send_command(dq_pkg::CMD_POP_BACK,   pick_word());
      send_command(dq_pkg::CMD_PEEK_FRONT, pick_word());
      send_command(dq_pkg::CMD_PEEK_BACK,  pick_word());
      // spare codes do nothing, payload ignored
      send_command(CMD_SPARE_LO, '1);
      send_command(CMD_SPARE_HI, '1);
      // push front from an empty deque wraps the front index below zero
      send_command(dq_pkg::CMD_PUSH_FRONT, '1);
      send_command(dq_pkg::CMD_PUSH_BACK,  '0);
      send_command(dq_pkg::CMD_PUSH_FRONT, 32'h8000_0001);
      send_command(dq_pkg::CMD_PEEK_FRONT, '0);
      send_command(dq_pkg::CMD_PEEK_BACK,  '1);
      send_command(dq_pkg::CMD_POP_BACK,   '0);
      send_command(dq_pkg::CMD_POP_FRONT,  '0);
      send_command(dq_pkg::CMD_POP_FRONT,  '0);
      // deque is empty again here
      send_command(dq_pkg::CMD_POP_BACK,   '0);
      send_command(dq_pkg::CMD_PUSH_BACK,  32'hA5A5_5A5A);
      send_command(dq_pkg::CMD_PEEK_BACK,  '0);
      send_command(dq_pkg::CMD_POP_FRONT,  '0);

      // random segments: push-heavy runs reach full and drop words, pop-heavy
      // runs drain to empty, balanced and peek-heavy runs stay in the middle
      while (random_sent < RANDOM_COMMANDS) begin
         segment_len = $urandom_range(8, 40);
         peek_bias   = 1'b0;
         case ($urandom_range(0, 3))
            0:       push_pct = 75;
            1:       push_pct = 22;
            2:       push_pct = 48;
            default: begin
               push_pct  = 45;
               peek_bias = 1'b1;
            end
         endcase
         // some segments run without any gaps
         sender_idle = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < segment_len && random_sent < RANDOM_COMMANDS; i++) begin
            if (random_sent == PAUSE_AT) begin
               wait_for_results();
            end
            send_command(pick_command(push_pct, peek_bias), pick_word());
            random_sent++;
         end
      end

      // all commands sent: wait for the last result, then watch for strays
      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && pending_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result side: random stalls per result, idle-free stretches, and one long
   // hold-off that lets the pipeline fill and push back on the command side
   initial begin
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (results_taken % 64 == 0) begin
            receiver_idle = ($urandom_range(0, 2) != 0);
         end
         stall = receiver_idle ? $urandom_range(0, 4) : 0;
         if (results_taken == HOLD_AFTER) begin
            stall = HOLD_CYCLES;
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         results_taken++;
      end
   end

endmodule
